>>> rtl/bphm_pkg.sv
// Shared widths, reset values and pipeline types for the block partition halo map.
package bphm_pkg;

   localparam int COORD_W    = 12;
   localparam int EXTENT_W   = 13;
   localparam int PARTS_W    = 9;
   localparam int PART_IDX_W = 8;
   localparam int OFFSET_W   = 14;
   localparam int PROD_W     = EXTENT_W + PARTS_W;

   // Owning block is always below 256, so eight quotient bits cover it.
   localparam int QUOT_W         = PART_IDX_W;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = QUOT_W / BITS_PER_STAGE;
   localparam int DVS_W          = EXTENT_W + QUOT_W;

   localparam int MAX_EXTENT = 4096;
   localparam int MAX_PARTS  = 256;

   localparam logic [EXTENT_W-1:0] EXTENT_RST   = 13'd16;
   localparam logic [PARTS_W-1:0]  PARTS_RST    = 9'd4;
   localparam logic [EXTENT_W-1:0] LENGTH_RST   = 13'd4;
   localparam logic [EXTENT_W-1:0] WRAP_ADJ_RST = 13'd4;

   typedef struct packed {
      logic [COORD_W-1:0] coord;
      logic [COORD_W-1:0] rem;
      logic [QUOT_W-1:0]  quot;
   } div_word_type;

endpackage

>>> rtl/bphm_req_if.sv
// Input channel carrying one lattice coordinate per word.
interface bphm_req_if import bphm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] coordinate;

   modport source (output valid, output coordinate, input ready);
   modport sink   (input valid, input coordinate, output ready);
endinterface

>>> rtl/bphm_rsp_if.sv
// Result channel carrying one block mapping per word.
interface bphm_rsp_if import bphm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [PART_IDX_W-1:0]      part_index;
   logic signed [OFFSET_W-1:0] local_offset;
   logic                       is_halo;
   logic                       last;
   logic                       bad_request;

   modport source (output valid, output part_index, output local_offset, output is_halo,
                   output last, output bad_request, input ready);
   modport sink   (input valid, input part_index, input local_offset, input is_halo,
                   input last, input bad_request, output ready);
endinterface

>>> rtl/block_partition_halo_map.sv
// Top level: maps a lattice coordinate to its owning block and halo neighbors.
// A coordinate crosses the quotient pipe and the serializer register before its first result word.
// One result word per cycle while rsp_chan.ready is high, one to three words per coordinate.
// The result-word serializer sets that rate; the quotient pipe takes one per cycle unless stalled.
// A write to a known register recomputes the block length, with req_chan.ready low meanwhile.
// Reset (synchronous, active high) loads extent 16, four blocks, open mode, empty pipe.
module block_partition_halo_map import bphm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bphm_req_if.sink    req_chan,
   bphm_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Register map, one 32-bit word each.
   localparam logic [1:0] REG_EXTENT   = 2'd0;
   localparam logic [1:0] REG_PARTS    = 2'd1;
   localparam logic [1:0] REG_PERIODIC = 2'd2;

   // Result slots inside one coordinate: lower neighbor, owner, upper neighbor.
   localparam logic [1:0] SEL_LO    = 2'd0;
   localparam logic [1:0] SEL_OWNER = 2'd1;
   localparam logic [1:0] SEL_HI    = 2'd2;

   typedef enum logic [2:0] {
      CFG_IDLE,
      CFG_LOAD,
      CFG_DIV,
      CFG_ROUND,
      CFG_PROD,
      CFG_CHECK
   } cfg_state_type;

   // ------------------------------------------------------------------
   // Configuration registers and block-length sequencer
   // ------------------------------------------------------------------
   cfg_state_type        cfg_state_ff;
   logic [EXTENT_W-1:0]  extent_ff;
   logic [PARTS_W-1:0]   part_count_ff;
   logic                 periodic_ff;
   logic [EXTENT_W-1:0]  part_length_ff;
   logic [EXTENT_W-1:0]  wrap_adj_ff;
   logic                 cfg_bad_ff;
   logic [EXTENT_W-1:0]  num_ff;
   logic [PARTS_W:0]     div_rem_ff;
   logic [EXTENT_W-1:0]  div_quo_ff;
   logic [3:0]           div_cnt_ff;
   logic [PROD_W-1:0]    prod_ff;

   logic                 csr_wr;
   logic                 csr_wr_known;
   logic [PARTS_W:0]     div_shift;
   logic                 div_ge;
   logic [PARTS_W-1:0]   parts_m1;

   assign pready       = 1'b1;
   assign csr_wr       = psel && penable && pwrite && pready;
   assign csr_wr_known = csr_wr && (paddr[3:2] == REG_EXTENT || paddr[3:2] == REG_PARTS ||
                                    paddr[3:2] == REG_PERIODIC);
   assign parts_m1     = part_count_ff - PARTS_W'(1);

   // One restoring step per cycle: shift in the next extent bit.
   assign div_shift = {div_rem_ff[PARTS_W-1:0], num_ff[EXTENT_W-1]};
   assign div_ge    = div_shift >= {1'b0, part_count_ff};

   always_comb begin
      unique case (paddr[3:2])
         REG_EXTENT:   prdata = 32'(extent_ff);
         REG_PARTS:    prdata = 32'(part_count_ff);
         REG_PERIODIC: prdata = 32'(periodic_ff);
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_state_ff   <= CFG_IDLE;
         extent_ff      <= EXTENT_RST;
         part_count_ff  <= PARTS_RST;
         periodic_ff    <= 1'b0;
         part_length_ff <= LENGTH_RST;
         wrap_adj_ff    <= WRAP_ADJ_RST;
         cfg_bad_ff     <= 1'b0;
      end else begin
         if (csr_wr_known) begin
            unique case (paddr[3:2])
               REG_EXTENT:   extent_ff     <= pwdata[EXTENT_W-1:0];
               REG_PARTS:    part_count_ff <= pwdata[PARTS_W-1:0];
               REG_PERIODIC: periodic_ff   <= pwdata[0];
               default:      ;
            endcase
            // Any write to a known register restarts the length computation from scratch.
            cfg_state_ff <= CFG_LOAD;
         end else begin
            unique case (cfg_state_ff)
               CFG_IDLE: ;
               CFG_LOAD: begin
                  num_ff       <= extent_ff;
                  div_rem_ff   <= '0;
                  div_quo_ff   <= '0;
                  div_cnt_ff   <= '0;
                  cfg_state_ff <= CFG_DIV;
               end
               CFG_DIV: begin
                  num_ff     <= {num_ff[EXTENT_W-2:0], 1'b0};
                  div_rem_ff <= div_ge ? div_shift - {1'b0, part_count_ff} : div_shift;
                  div_quo_ff <= {div_quo_ff[EXTENT_W-2:0], div_ge};
                  div_cnt_ff <= div_cnt_ff + 4'd1;
                  if (div_cnt_ff == 4'(EXTENT_W - 1)) begin
                     cfg_state_ff <= CFG_ROUND;
                  end
               end
               CFG_ROUND: begin
                  // Round the quotient up; no blocks means zero length.
                  if (part_count_ff == '0) begin
                     part_length_ff <= '0;
                  end else begin
                     part_length_ff <= div_quo_ff + EXTENT_W'(div_rem_ff != '0);
                  end
                  cfg_state_ff <= CFG_PROD;
               end
               CFG_PROD: begin
                  prod_ff      <= PROD_W'(part_length_ff) * PROD_W'(parts_m1);
                  cfg_state_ff <= CFG_CHECK;
               end
               CFG_CHECK: begin
                  cfg_bad_ff <= (part_count_ff == '0) ||
                                (part_count_ff > PARTS_W'(MAX_PARTS)) ||
                                (extent_ff > EXTENT_W'(MAX_EXTENT)) ||
                                (extent_ff <= EXTENT_W'(part_count_ff)) ||
                                (prod_ff >= PROD_W'(extent_ff));
                  // Start of the wrapped lower neighbor sits the length of the short last
                  // block below zero: extent minus length*(parts-1).
                  wrap_adj_ff  <= extent_ff - prod_ff[EXTENT_W-1:0];
                  cfg_state_ff <= CFG_IDLE;
               end
               default: cfg_state_ff <= CFG_IDLE;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Quotient pipe: coordinate / part_length, two quotient bits a stage
   // ------------------------------------------------------------------
   div_word_type st_ff [DIV_STAGES+1];
   div_word_type st_in [DIV_STAGES+1];
   logic         v_ff  [DIV_STAGES+1];
   logic         v_in  [DIV_STAGES+1];
   logic         rdy   [DIV_STAGES+2];

   assign st_in[0]       = '{coord: req_chan.coordinate, rem: req_chan.coordinate, quot: '0};
   assign req_chan.ready = rdy[0] && (cfg_state_ff == CFG_IDLE);
   assign v_in[0]        = req_chan.valid && (cfg_state_ff == CFG_IDLE);

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_vin
      assign v_in[k] = v_ff[k-1];
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      always_comb begin
         div_word_type w;
         logic [DVS_W-1:0] dvs;
         w = st_ff[k];
         for (int j = 0; j < BITS_PER_STAGE; j++) begin
            dvs = DVS_W'(part_length_ff) << (QUOT_W - 1 - k * BITS_PER_STAGE - j);
            if (DVS_W'(w.rem) >= dvs) begin
               w.rem = w.rem - dvs[COORD_W-1:0];
               w.quot[QUOT_W-1-k*BITS_PER_STAGE-j] = 1'b1;
            end
         end
         st_in[k+1] = w;
      end
   end

   // A stage takes a new word when it is empty or its word moves on.
   for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end

   for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Candidate blocks for the finished quotient
   // ------------------------------------------------------------------
   div_word_type          fin;
   logic                  own_first;
   logic                  own_last;
   logic                  item_bad;
   logic [PART_IDX_W-1:0] part_in [3];
   logic [OFFSET_W-1:0]   off_in  [3];
   logic [2:0]            mask_in;
   logic [OFFSET_W-1:0]   x14;
   logic [OFFSET_W-1:0]   r14;
   logic [OFFSET_W-1:0]   q14;

   assign fin       = st_ff[DIV_STAGES];
   assign own_first = fin.quot == '0;
   assign own_last  = {1'b0, fin.quot} == parts_m1;
   assign item_bad  = cfg_bad_ff || ({1'b0, fin.coord} >= extent_ff);
   assign x14       = OFFSET_W'(fin.coord);
   assign r14       = OFFSET_W'(fin.rem);
   assign q14       = OFFSET_W'(part_length_ff);

   always_comb begin
      part_in[SEL_LO]    = own_first ? parts_m1[PART_IDX_W-1:0] : fin.quot - PART_IDX_W'(1);
      part_in[SEL_OWNER] = fin.quot;
      part_in[SEL_HI]    = own_last ? '0 : fin.quot + PART_IDX_W'(1);
      // Wrapped neighbors measure from a start shifted by one extent.
      off_in[SEL_LO]     = own_first ? x14 + OFFSET_W'(wrap_adj_ff) : r14 + q14;
      off_in[SEL_OWNER]  = r14;
      off_in[SEL_HI]     = own_last ? x14 - OFFSET_W'(extent_ff) : r14 - q14;
      // Open mode drops neighbors past either end of the axis.
      mask_in = {periodic_ff || !own_last, 1'b1, periodic_ff || !own_first};
      if (item_bad) begin
         part_in[SEL_OWNER] = '0;
         off_in[SEL_OWNER]  = '0;
         mask_in            = 3'b010;
      end
   end

   // ------------------------------------------------------------------
   // Result serializer: one word per handshake, lowest pending slot first
   // ------------------------------------------------------------------
   logic                  rs_valid_ff;
   logic [PART_IDX_W-1:0] rs_part_ff [3];
   logic [OFFSET_W-1:0]   rs_off_ff  [3];
   logic [2:0]            rs_mask_ff;
   logic                  rs_bad_ff;
   logic [1:0]            sel;
   logic                  cur_last;
   logic                  rsp_take;

   always_comb begin
      if (rs_mask_ff[SEL_LO]) begin
         sel = SEL_LO;
      end else if (rs_mask_ff[SEL_OWNER]) begin
         sel = SEL_OWNER;
      end else begin
         sel = SEL_HI;
      end
      case (sel)
         SEL_LO:    cur_last = !rs_mask_ff[SEL_OWNER] && !rs_mask_ff[SEL_HI];
         SEL_OWNER: cur_last = !rs_mask_ff[SEL_HI];
         default:   cur_last = 1'b1;
      endcase
   end

   assign rsp_take          = rs_valid_ff && rsp_chan.ready;
   assign rdy[DIV_STAGES+1] = !rs_valid_ff || (rsp_chan.ready && cur_last);

   assign rsp_chan.valid        = rs_valid_ff;
   assign rsp_chan.part_index   = rs_part_ff[sel];
   assign rsp_chan.local_offset = $signed(rs_off_ff[sel]);
   assign rsp_chan.is_halo      = sel != SEL_OWNER;
   assign rsp_chan.last         = cur_last;
   assign rsp_chan.bad_request  = rs_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_valid_ff <= 1'b0;
      end else if (rdy[DIV_STAGES+1]) begin
         rs_valid_ff <= v_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[DIV_STAGES+1]) begin
         rs_part_ff <= part_in;
         rs_off_ff  <= off_in;
         rs_mask_ff <= mask_in;
         rs_bad_ff  <= item_bad;
      end else if (rsp_take) begin
         // Drop the slot just delivered; the next pending one follows.
         rs_mask_ff[sel] <= 1'b0;
      end
   end

`ifndef SYNTH
   a_mask_nonempty: assert property (@(posedge clock) disable iff (reset)
      rs_valid_ff |-> (rs_mask_ff != 3'b000))
      else $error("serializer holds a word with no pending slot");

   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.bad_request) |-> (rsp_chan.last && !rsp_chan.is_halo))
      else $error("error result is not a single owner word");

   a_more_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last) |=> rsp_chan.valid)
      else $error("coordinate ended before its last word");

   a_cfg_blocks_input: assert property (@(posedge clock) disable iff (reset)
      csr_wr_known |=> !req_chan.ready)
      else $error("input taken while block length is recomputed");
`endif

endmodule

>>> verif/block_partition_halo_map_tb.sv
// Self-checking testbench for the block partition halo map: directed table, then random phases.
module block_partition_halo_map_tb;
   import bphm_pkg::*;

   // Register indexes; the byte address is four times the index.
   localparam int REG_EXTENT   = 0;
   localparam int REG_PARTS    = 1;
   localparam int REG_PERIODIC = 2;
   localparam int REG_SPARE    = 3;   // no register behind it, writes must change nothing

   localparam int SETTLE      = 8;
   localparam int TAIL        = 20;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 26;
   localparam int unsigned LIMIT_CYCLES = 200000;

   // One result word as it leaves the block.
   typedef struct packed {
      logic [PART_IDX_W-1:0]      part_index;
      logic signed [OFFSET_W-1:0] local_offset;
      logic                       is_halo;
      logic                       last;
      logic                       bad_request;
   } map_word_type;

   localparam map_word_type BAD_WORD = {8'd0, 14'sd0, 1'b0, 1'b1, 1'b1};
   localparam map_word_type NO_WORD  = '0;

   typedef enum logic [1:0] {ROW_WRITE, ROW_COORD} row_kind_type;
   typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_EVERY4, STALL_LONG} stall_mode_type;

   // One line of the directed table: a register write or a coordinate, the latter with
   // its words typed in where they are obvious (n_known of zero hands it to the predictor).
   typedef struct packed {
      row_kind_type        kind;
      logic [1:0]          reg_idx;
      logic [31:0]         value;
      logic [COORD_W-1:0]  coord;
      logic [1:0]          n_known;
      map_word_type [2:0]  known;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   bphm_req_if req_chan ();
   bphm_rsp_if rsp_chan ();

   block_partition_halo_map DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Shadow copy of the block's settings, updated at the edge that writes them.
   logic [EXTENT_W-1:0] cur_extent   = EXTENT_RST;
   logic [PARTS_W-1:0]  cur_parts    = PARTS_RST;
   logic                cur_periodic = 1'b0;
   logic [EXTENT_W-1:0] cur_length   = LENGTH_RST;

   map_word_type  pending_words [$];   // words still owed by the block, oldest first
   plan_row_type  plan [$];
   int unsigned   mismatches = 0;
   int unsigned   cycles     = 0;
   int            burst_left = 0;

   // Clock: period 12.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops words.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Append one word to the tail of the owed list.
   function automatic void owe_word(input map_word_type w);
      pending_words = {pending_words, w};
   endfunction

   function automatic map_word_type map_word(input int part, input int off, input bit halo,
                                             input bit fin, input bit bad);
      map_word_type w;
      w.part_index   = part[PART_IDX_W-1:0];
      w.local_offset = off[OFFSET_W-1:0];
      w.is_halo      = halo;
      w.last         = fin;
      w.bad_request  = bad;
      return w;
   endfunction

   function automatic string word_text(input map_word_type w);
      return $sformatf("part %0d offset %0d halo %b last %b bad %b", w.part_index,
                       $signed(w.local_offset), w.is_halo, w.last, w.bad_request);
   endfunction

   // Mirror a register write into the shadow settings and redo the block length.
   function automatic void apply_reg(input int idx, input logic [31:0] value);
      int n, p;
      case (idx)
         REG_EXTENT:   cur_extent   = value[EXTENT_W-1:0];
         REG_PARTS:    cur_parts    = value[PARTS_W-1:0];
         REG_PERIODIC: cur_periodic = value[0];
         default:      return;
      endcase
      n = cur_extent;
      p = cur_parts;
      if (p == 0) cur_length = '0;
      else cur_length = (n + p - 1) / p;
   endfunction

   // Value a register should read back with, from the shadow settings.
   function automatic logic [31:0] reg_value(input int idx);
      case (idx)
         REG_EXTENT:   return 32'(cur_extent);
         REG_PARTS:    return 32'(cur_parts);
         REG_PERIODIC: return 32'(cur_periodic);
         default:      return 32'd0;
      endcase
   endfunction

   // Work out every word one coordinate owes and queue them in emission order.
   function automatic void map_coordinate(input logic [COORD_W-1:0] coord);
      int x, n, p, q, owner, lo, hi, wraps;
      x = coord;
      n = cur_extent;
      p = cur_parts;
      q = cur_length;
      // Any broken setting, or a site off the lattice, gives the single flagged word.
      if (p < 1 || p > MAX_PARTS || n > MAX_EXTENT || n <= p || q == 0 ||
          q * (p - 1) >= n || x >= n) begin
         owe_word(BAD_WORD);
         return;
      end
      owner = x / q;
      lo    = owner - 1;
      hi    = owner + 1;
      // Open ends: drop neighbors beyond the first and last block.
      if (!cur_periodic) begin
         if (lo < 0) lo = 0;
         if (hi > p - 1) hi = p - 1;
      end
      for (int idx = lo; idx <= hi; idx++) begin
         // Wrapped neighbors: fold the index and shift the block start by one extent.
         wraps = (idx < 0) ? -1 : ((idx >= p) ? 1 : 0);
         owe_word(map_word(idx - wraps * p, x - (idx * q + (n - p * q) * wraps),
                           idx != owner, idx == hi, 1'b0));
      end
   endfunction

   // Mostly sites on the lattice, a share right at block edges, some anywhere at all.
   function automatic logic [COORD_W-1:0] pick_coordinate();
      int lim, c;
      lim = (cur_extent == 0) ? 0 : ((cur_extent > MAX_EXTENT) ? MAX_EXTENT : cur_extent) - 1;
      case ($urandom_range(0, 9))
         0:       c = $urandom_range(0, 4095);
         1, 2:    c = int'($urandom_range(0, cur_parts)) * int'(cur_length) +
                      int'($urandom_range(0, 2)) - 1;
         default: c = $urandom_range(0, lim);
      endcase
      if (c < 0) c = 0;
      if (c > 4095) c = 4095;
      return c[COORD_W-1:0];
   endfunction

   function automatic void add_write(input int idx, input logic [31:0] value);
      plan_row_type r;
      r         = '0;
      r.kind    = ROW_WRITE;
      r.reg_idx = idx[1:0];
      r.value   = value;
      plan      = {plan, r};
   endfunction

   function automatic void add_known(input logic [COORD_W-1:0] coord, input int n,
                                     input map_word_type w0, input map_word_type w1,
                                     input map_word_type w2);
      plan_row_type r;
      r          = '0;
      r.kind     = ROW_COORD;
      r.coord    = coord;
      r.n_known  = n[1:0];
      r.known[0] = w0;
      r.known[1] = w1;
      r.known[2] = w2;
      plan       = {plan, r};
   endfunction

   // Offer one coordinate and hold it until the block takes it. Open a new burst,
   // often after an idle gap, whenever the current one runs out.
   task automatic send_coordinate(input logic [COORD_W-1:0] coord);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.coordinate <= coord;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Drop valid, wait for every owed word, then let the pipe settle.
   task automatic wait_drained(input int settle);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value when pready is seen.
   task automatic write_reg(input int idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx[1:0], 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      apply_reg(idx, value);
      @(negedge clock);
      // Read the register back at the same address.
      if (prdata !== reg_value(idx)) begin
         mismatches++;
         $display("%0t: register %0d readback: expected %0h, got %0h", $time, idx,
                  reg_value(idx), prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Result side: stall in stretches, each with a pattern of its own.
   stall_mode_type stall_mode   = STALL_NONE;
   int             stretch_left = 0;
   int             hold_left    = 0;

   always @(negedge clock) begin
      if (stretch_left == 0) begin
         stall_mode   = stall_mode_type'($urandom_range(0, 3));
         stretch_left = $urandom_range(20, 80);
      end
      stretch_left--;
      case (stall_mode)
         STALL_NONE:   rsp_chan.ready <= 1'b1;
         STALL_COIN:   rsp_chan.ready <= $urandom_range(0, 1);
         STALL_EVERY4: rsp_chan.ready <= (stretch_left % 4 == 0);
         default: begin
            // Long stalls: hold ready low, then raise it to take one word, and repeat.
            if (hold_left == 0) begin
               rsp_chan.ready <= 1'b1;
               hold_left = $urandom_range(1, 8);
            end else begin
               rsp_chan.ready <= 1'b0;
               hold_left--;
            end
         end
      endcase
   end

   // Check every accepted word against the oldest one owed.
   always @(posedge clock) begin
      map_word_type seen, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.part_index   = rsp_chan.part_index;
         seen.local_offset = rsp_chan.local_offset;
         seen.is_halo      = rsp_chan.is_halo;
         seen.last         = rsp_chan.last;
         seen.bad_request  = rsp_chan.bad_request;
         if (pending_words.size() == 0) begin
            mismatches++;
            $display("%0t: word with none owed: expected nothing, got %s", $time,
                     word_text(seen));
         end else begin
            want = pending_words.pop_front();
            if (seen !== want) begin
               mismatches++;
               $display("%0t: mismatch: expected %s, got %s", $time, word_text(want),
                        word_text(seen));
            end
         end
      end
   end

   // Stimulus: directed table first, then random phases with fresh settings each.
   initial begin
      plan_row_type row;
      logic [31:0]  ext, parts, mode;
      logic [COORD_W-1:0] c;

      req_chan.valid      = 1'b0;
      req_chan.coordinate = '0;
      rsp_chan.ready      = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      reset   = 1'b1;

      // Reset settings: 16 sites, four blocks of four, open ends.
      add_known(0, 2, map_word(0, 0, 0, 0, 0), map_word(1, -4, 1, 1, 0), NO_WORD);
      add_known(15, 2, map_word(2, 7, 1, 0, 0), map_word(3, 3, 0, 1, 0), NO_WORD);
      add_known(5, 3, map_word(0, 5, 1, 0, 0), map_word(1, 1, 0, 0, 0),
                map_word(2, -3, 1, 1, 0));
      add_known(16, 1, BAD_WORD, NO_WORD, NO_WORD);      // first site off the lattice
      add_known(4095, 1, BAD_WORD, NO_WORD, NO_WORD);
      // Periodic: both ends wrap to the far block.
      add_write(REG_PERIODIC, 32'd1);
      add_known(0, 3, map_word(3, 4, 1, 0, 0), map_word(0, 0, 0, 0, 0),
                map_word(1, -4, 1, 1, 0));
      add_known(15, 3, map_word(2, 7, 1, 0, 0), map_word(3, 3, 0, 0, 0),
                map_word(0, -1, 1, 1, 0));
      // Single block in periodic mode: block 0 three times, halos shifted by one extent.
      add_write(REG_EXTENT, 32'd2);
      add_write(REG_PARTS, 32'd1);
      add_known(0, 3, map_word(0, 2, 1, 0, 0), map_word(0, 0, 0, 0, 0),
                map_word(0, -2, 1, 1, 0));
      add_known(1, 0, NO_WORD, NO_WORD, NO_WORD);
      add_known(2, 1, BAD_WORD, NO_WORD, NO_WORD);
      // Junk above bit 0 must not leak into the mode.
      add_write(REG_PERIODIC, 32'hFFFF_FFFE);
      add_known(1, 1, map_word(0, 1, 0, 1, 0), NO_WORD, NO_WORD);
      // Largest lattice and block count.
      add_write(REG_EXTENT, 32'd4096);
      add_write(REG_PARTS, 32'd256);
      add_known(4095, 0, NO_WORD, NO_WORD, NO_WORD);
      add_known(0, 0, NO_WORD, NO_WORD, NO_WORD);
      add_known(2047, 0, NO_WORD, NO_WORD, NO_WORD);
      add_write(REG_PERIODIC, 32'd1);
      add_known(4095, 0, NO_WORD, NO_WORD, NO_WORD);
      add_known(0, 0, NO_WORD, NO_WORD, NO_WORD);
      // Broken settings: extent too large, zero blocks, too many blocks,
      // extent not above the block count, last block left empty.
      add_write(REG_EXTENT, 32'h0000_1FFF);
      add_known(0, 1, BAD_WORD, NO_WORD, NO_WORD);
      add_write(REG_EXTENT, 32'd10);
      add_write(REG_PARTS, 32'd0);
      add_known(3, 1, BAD_WORD, NO_WORD, NO_WORD);
      add_write(REG_PARTS, 32'd511);
      add_known(3, 1, BAD_WORD, NO_WORD, NO_WORD);
      add_write(REG_PARTS, 32'd10);
      add_known(3, 1, BAD_WORD, NO_WORD, NO_WORD);
      add_write(REG_EXTENT, 32'd9);
      add_write(REG_PARTS, 32'd4);
      add_known(0, 1, BAD_WORD, NO_WORD, NO_WORD);
      // Short last block, with a write to the empty index that must change nothing.
      add_write(REG_EXTENT, 32'd17);
      add_write(REG_SPARE, 32'hFFFF_FFFF);
      add_known(0, 0, NO_WORD, NO_WORD, NO_WORD);
      add_known(16, 0, NO_WORD, NO_WORD, NO_WORD);
      add_write(REG_PERIODIC, 32'd0);
      add_known(16, 0, NO_WORD, NO_WORD, NO_WORD);
      add_known(12, 0, NO_WORD, NO_WORD, NO_WORD);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the table; writes only go in once the block has gone quiet.
      for (int r = 0; r < plan.size(); r++) begin
         row = plan[r];
         if (row.kind == ROW_WRITE) begin
            wait_drained(SETTLE);
            write_reg(row.reg_idx, row.value);
         end else begin
            send_coordinate(row.coord);
            if (row.n_known == 0) map_coordinate(row.coord);
            else for (int w = 0; w < row.n_known; w++) owe_word(row.known[w]);
         end
      end

      // Random phases: extremes first, then random settings, now and then broken ones.
      for (int s = 0; s < PHASES; s++) begin
         case (s)
            0: begin ext = 2;    parts = 1;   mode = 0; end
            1: begin ext = 2;    parts = 1;   mode = 1; end
            2: begin ext = 4096; parts = 256; mode = 0; end
            3: begin ext = 4096; parts = 256; mode = 1; end
            default: begin
               mode = $urandom_range(0, 1);
               if ($urandom_range(0, 7) == 0) begin
                  ext   = $urandom_range(0, 8191);
                  parts = $urandom_range(0, 511);
               end else begin
                  ext   = $urandom_range(2, 4096);
                  parts = $urandom_range(1, (ext > 256) ? 256 : ext - 1);
               end
            end
         endcase
         wait_drained(SETTLE);
         // Fill the unused upper bits with noise; only the field bits count.
         write_reg(REG_EXTENT, ($urandom << EXTENT_W) | ext);
         write_reg(REG_PARTS, ($urandom << PARTS_W) | parts);
         write_reg(REG_PERIODIC, ($urandom << 1) | mode);
         if (s % 3 == 0) write_reg(REG_SPARE, $urandom);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // Hold off mid-phase until the block owes nothing.
            if (k == PHASE_ITEMS / 2 && s % 2 == 1) wait_drained(0);
            c = pick_coordinate();
            send_coordinate(c);
            map_coordinate(c);
         end
      end

      wait_drained(TAIL);
      if (mismatches == 0 && pending_words.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
rtl/bphm_pkg.sv
rtl/bphm_req_if.sv
rtl/bphm_rsp_if.sv
rtl/block_partition_halo_map.sv
verif/block_partition_halo_map_tb.sv
